// File: design/dqr_pkg.sv
// Shared constants, mode and status codes, and controller/datapath link types for the deque.
`timescale 1ns / 1ps

package dqr_pkg;

    // Default store depth
    localparam int DEPTH_DEF = 64;

    // Fixed field widths
    localparam int MODE_W  = 3;
    localparam int WORD_W  = 32;
    localparam int CNT_O_W = 7;
    localparam int STAT_W  = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SHIFT_L    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SHIFT_R    = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture the input beat
        logic apply;      // perform an end operation
        logic rm_init;    // start a remove sweep
        logic rm_run;     // advance the remove sweep
        logic rm_commit;  // close the remove sweep
        logic out_load;   // load the result register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_remove;
        logic rm_done;
    } t_dp_stat;

endpackage

// File: design/dqr_ctrl.sv
// Controller state machine for the deque: sequences update, sweep, read and result load.
`timescale 1ns / 1ps

module dqr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  dqr_pkg::t_dp_stat i_stat,
    output dqr_pkg::t_dp_cmd  o_cmd
);
    import dqr_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_RMV  = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;
    t_dp_cmd    cmd;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_stat.is_remove) begin
                    cmd.rm_init = 1'b1;
                    n_state     = ST_RMV;
                end else begin
                    cmd.apply = 1'b1;
                    n_state   = ST_READ;
                end
            end
            ST_RMV: begin
                if (i_stat.rm_done) begin
                    cmd.rm_commit = 1'b1;
                    n_state       = ST_READ;
                end else begin
                    cmd.rm_run = 1'b1;
                end
            end
            ST_READ: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the result beat until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while pending");

    // An accepted beat always goes to the update step
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted beat did not reach update step");

    // A loaded result shows up as valid with the controller idle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> (r_out_valid && r_state == ST_IDLE))
        else $error("loaded result not presented");

endmodule

// File: design/dqr_dp.sv
// Datapath for the deque: circular store, head and count, remove sweep and result register.
`timescale 1ns / 1ps

module dqr_dp #(
    parameter int DEPTH = dqr_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dqr_pkg::t_dp_cmd                 i_cmd,
    output dqr_pkg::t_dp_stat                o_stat,
    input  logic [dqr_pkg::MODE_W-1:0]       i_mode,
    input  logic signed [dqr_pkg::WORD_W-1:0] i_value,
    output logic signed [dqr_pkg::WORD_W-1:0] o_front_word,
    output logic signed [dqr_pkg::WORD_W-1:0] o_back_word,
    output logic [dqr_pkg::CNT_O_W-1:0]      o_entry_count,
    output logic                             o_is_empty,
    output logic [dqr_pkg::CNT_O_W-1:0]      o_removed_count,
    output logic [dqr_pkg::STAT_W-1:0]       o_status
);
    import dqr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    // Storage
    logic [WORD_W-1:0] r_mem [DEPTH];

    // Item and pointer registers
    logic [MODE_W-1:0] r_mode;
    logic [WORD_W-1:0] r_value;
    logic [AW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic [STAT_W-1:0] r_status;
    logic [CW-1:0]     r_removed;

    // Remove sweep
    logic [CW-1:0]     r_rd_idx;
    logic [CW-1:0]     r_kept;
    logic              r_cmp_vld;

    // Read data
    logic [WORD_W-1:0] r_rd_a;
    logic [WORD_W-1:0] r_rd_b;

    // Result register
    logic [WORD_W-1:0]  r_front_o;
    logic [WORD_W-1:0]  r_back_o;
    logic [CNT_O_W-1:0] r_cnt_o;
    logic               r_empty_o;
    logic [CNT_O_W-1:0] r_rem_o;
    logic [STAT_W-1:0]  r_stat_o;

    logic              is_full;
    logic              is_empty;
    logic [AW-1:0]     head_inc;
    logic [AW-1:0]     head_dec;
    logic [AW-1:0]     slot_tail;
    logic [AW-1:0]     slot_last;
    logic [CW-1:0]     last_off;
    logic              rd_more;
    logic              rm_keep;

    logic [AW-1:0]     ap_head;
    logic [CW-1:0]     ap_count;
    logic [STAT_W-1:0] ap_status;
    logic              ap_wr;
    logic [AW-1:0]     ap_addr;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     rd_addr_b;

    // Wrap head plus offset into the store, offset at most DEPTH
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW + 1)'(head) + {1'b0, off};
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    assign is_full   = (r_count == DEPTH_C);
    assign is_empty  = (r_count == '0);
    assign head_inc  = (r_head == LAST_A) ? '0 : r_head + 1'b1;
    assign head_dec  = (r_head == '0) ? LAST_A : r_head - 1'b1;
    assign slot_tail = slot_of(r_head, r_count);
    assign last_off  = is_empty ? '0 : r_count - 1'b1;
    assign slot_last = slot_of(r_head, last_off);
    assign rd_more   = (r_rd_idx != r_count);
    assign rm_keep   = r_cmp_vld && (r_rd_a != r_value);

    assign o_stat.is_remove = (r_mode == MODE_REMOVE);
    assign o_stat.rm_done   = !rd_more && !r_cmp_vld;

    // Decode an end operation
    always_comb begin
        ap_head   = r_head;
        ap_count  = r_count;
        ap_status = STAT_OK;
        ap_wr     = 1'b0;
        ap_addr   = head_dec;
        case (r_mode)
            MODE_PUSH_FRONT: begin
                if (is_full) begin
                    ap_status = STAT_FULL;
                end else begin
                    ap_head  = head_dec;
                    ap_count = r_count + 1'b1;
                    ap_wr    = 1'b1;
                    ap_addr  = head_dec;
                end
            end
            MODE_PUSH_BACK: begin
                if (is_full) begin
                    ap_status = STAT_FULL;
                end else begin
                    ap_count = r_count + 1'b1;
                    ap_wr    = 1'b1;
                    ap_addr  = slot_tail;
                end
            end
            MODE_POP_FRONT: begin
                if (is_empty) begin
                    ap_status = STAT_EMPTY;
                end else begin
                    ap_head  = head_inc;
                    ap_count = r_count - 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (is_empty) begin
                    ap_status = STAT_EMPTY;
                end else begin
                    ap_count = r_count - 1'b1;
                end
            end
            MODE_SHIFT_L: begin
                ap_wr = 1'b1;
                if (is_empty) begin
                    ap_status = STAT_EMPTY;
                    ap_count  = CW'(1);
                    ap_addr   = r_head;
                end else begin
                    ap_head = head_inc;
                    ap_addr = slot_tail;
                end
            end
            MODE_SHIFT_R: begin
                ap_wr   = 1'b1;
                ap_head = head_dec;
                ap_addr = head_dec;
                if (is_empty) begin
                    ap_status = STAT_EMPTY;
                    ap_count  = CW'(1);
                end
            end
            default: begin
                ap_status = STAT_OK;
            end
        endcase
    end

    // Select the write port source
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ap_addr;
        wr_data = r_value;
        if (i_cmd.apply) begin
            wr_en = ap_wr;
        end else if (i_cmd.rm_run && rm_keep) begin
            wr_en   = 1'b1;
            wr_addr = slot_of(r_head, r_kept);
            wr_data = r_rd_a;
        end
    end

    // Select read addresses: sweep slot or front, and back
    assign rd_addr_a = (i_cmd.rm_run && rd_more) ? slot_of(r_head, r_rd_idx) : r_head;
    assign rd_addr_b = slot_last;

    // Store write and registered reads
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_value <= i_value;
        end
    end

    // Update head, count and sweep state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_kept    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                r_head  <= ap_head;
                r_count <= ap_count;
            end
            if (i_cmd.rm_init) begin
                r_rd_idx  <= '0;
                r_kept    <= '0;
                r_cmp_vld <= 1'b0;
            end
            if (i_cmd.rm_run) begin
                r_cmp_vld <= rd_more;
                if (rd_more) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                if (rm_keep) begin
                    r_kept <= r_kept + 1'b1;
                end
            end
            if (i_cmd.rm_commit) begin
                r_count <= r_kept;
            end
        end
    end

    // Track status and removal tally of the current item
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_status  <= ap_status;
            r_removed <= '0;
        end
        if (i_cmd.rm_init) begin
            r_status <= STAT_OK;
        end
        if (i_cmd.rm_commit) begin
            r_removed <= r_count - r_kept;
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_front_o <= is_empty ? '0 : r_rd_a;
            r_back_o  <= is_empty ? '0 : r_rd_b;
            r_cnt_o   <= CNT_O_W'(r_count);
            r_empty_o <= is_empty;
            r_rem_o   <= CNT_O_W'(r_removed);
            r_stat_o  <= r_status;
        end
    end

    assign o_front_word    = r_front_o;
    assign o_back_word     = r_back_o;
    assign o_entry_count   = r_cnt_o;
    assign o_is_empty      = r_empty_o;
    assign o_removed_count = r_rem_o;
    assign o_status        = r_stat_o;

    // Count stays within the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count beyond depth");

    // Compaction never writes ahead of the read pointer
    a_kept_trails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= r_rd_idx)
        else $error("compaction overtook sweep");

    // A committed sweep never grows the store
    a_commit_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rm_commit |=> (r_count <= $past(r_count)))
        else $error("remove increased entry count");

endmodule

// File: design/bounded_deque_with_remove.sv
// Top level of the bounded double-ended queue with remove-by-value.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------------
//  input    | i_in_valid / o_in_ready  | i_mode, i_value
//  output   | o_out_valid / i_out_ready| o_front_word, o_back_word, o_entry_count,
//           |                          | o_is_empty, o_removed_count, o_status
//
// Push, pop and shift pass through accept, store update, port read and result load.
// Remove replaces the store update with a sweep: the store's single write port
// compacts one entry per cycle while the sweep reads the next one.
// Reset is synchronous and active low; it empties the queue and clears pending results.
// A result waits in the output register while the next input beat is accepted; a stalled
// output holds the controller only at the result load step.
`timescale 1ns / 1ps

module bounded_deque_with_remove #(
    parameter int DEPTH = dqr_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [dqr_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [dqr_pkg::WORD_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [dqr_pkg::WORD_W-1:0] o_front_word,
    output logic signed [dqr_pkg::WORD_W-1:0] o_back_word,
    output logic [dqr_pkg::CNT_O_W-1:0]       o_entry_count,
    output logic                              o_is_empty,
    output logic [dqr_pkg::CNT_O_W-1:0]       o_removed_count,
    output logic [dqr_pkg::STAT_W-1:0]        o_status
);
    import dqr_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequence each item
    dqr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Hold the store and compute results
    dqr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_mode          (i_mode),
        .i_value         (i_value),
        .o_front_word    (o_front_word),
        .o_back_word     (o_back_word),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty),
        .o_removed_count (o_removed_count),
        .o_status        (o_status)
    );

endmodule

// File: bench/deque_result_checker.sv
// Result checker for the deque: tracks the expected store and compares every output beat.
`timescale 1ns / 1ps

module deque_result_checker #(
    parameter int DEPTH = dqr_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [dqr_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [dqr_pkg::WORD_W-1:0] i_value,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [dqr_pkg::WORD_W-1:0] i_front_word,
    input  logic signed [dqr_pkg::WORD_W-1:0] i_back_word,
    input  logic [dqr_pkg::CNT_O_W-1:0]       i_entry_count,
    input  logic                              i_is_empty,
    input  logic [dqr_pkg::CNT_O_W-1:0]       i_removed_count,
    input  logic [dqr_pkg::STAT_W-1:0]        i_status,
    output int                                o_fail_count,
    output int                                o_pending_count
);
    import dqr_pkg::*;

    typedef struct packed {
        logic signed [WORD_W-1:0] front_word;
        logic signed [WORD_W-1:0] back_word;
        logic [CNT_O_W-1:0]       entry_count;
        logic                     is_empty;
        logic [CNT_O_W-1:0]       removed_count;
        logic [STAT_W-1:0]        status;
    } t_deque_result;

    // Shadow copy of the circular store
    logic [WORD_W-1:0] ring [DEPTH];
    int unsigned       front_slot = 0;
    int unsigned       held = 0;

    t_deque_result     expected_q [$];
    t_deque_result     want;
    int                mismatches = 0;
    int                outstanding = 0;

    assign o_fail_count    = mismatches;
    assign o_pending_count = outstanding;

    function automatic int unsigned slot_of(input int unsigned offset);
        return (front_slot + offset) % DEPTH;
    endfunction

    function automatic bit insert_front(input logic [WORD_W-1:0] word);
        if (held >= DEPTH) return 1'b0;
        front_slot = (front_slot + DEPTH - 1) % DEPTH;
        ring[front_slot] = word;
        held++;
        return 1'b1;
    endfunction

    function automatic bit insert_back(input logic [WORD_W-1:0] word);
        if (held >= DEPTH) return 1'b0;
        ring[slot_of(held)] = word;
        held++;
        return 1'b1;
    endfunction

    function automatic bit drop_front();
        if (held == 0) return 1'b0;
        front_slot = (front_slot + 1) % DEPTH;
        held--;
        return 1'b1;
    endfunction

    function automatic bit drop_back();
        if (held == 0) return 1'b0;
        held--;
        return 1'b1;
    endfunction

    // Compact the store in place, keeping the order of survivors
    function automatic int unsigned purge_matches(input logic [WORD_W-1:0] word);
        int unsigned kept;
        int unsigned gone;
        logic [WORD_W-1:0] entry;
        kept = 0;
        for (int unsigned k = 0; k < held; k++) begin
            entry = ring[slot_of(k)];
            if (entry != word) begin
                ring[slot_of(kept)] = entry;
                kept++;
            end
        end
        gone = held - kept;
        held = kept;
        return gone;
    endfunction

    // Apply one operation beat to the shadow store and build its result
    task automatic predict_beat(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] word,
                                output t_deque_result res);
        int unsigned       gone;
        logic [STAT_W-1:0] st;
        gone = 0;
        st   = STAT_OK;
        case (mode)
            MODE_PUSH_FRONT: if (!insert_front(word)) st = STAT_FULL;
            MODE_PUSH_BACK:  if (!insert_back(word)) st = STAT_FULL;
            MODE_POP_FRONT:  if (!drop_front()) st = STAT_EMPTY;
            MODE_POP_BACK:   if (!drop_back()) st = STAT_EMPTY;
            MODE_REMOVE:     gone = purge_matches(word);
            MODE_SHIFT_L: begin
                if (!drop_front()) st = STAT_EMPTY;
                void'(insert_back(word));
            end
            MODE_SHIFT_R: begin
                if (!drop_back()) st = STAT_EMPTY;
                void'(insert_front(word));
            end
            default: ;
        endcase
        res.front_word    = (held == 0) ? '0 : ring[slot_of(0)];
        res.back_word     = (held == 0) ? '0 : ring[slot_of(held - 1)];
        res.entry_count   = CNT_O_W'(held);
        res.is_empty      = (held == 0);
        res.removed_count = CNT_O_W'(gone);
        res.status        = st;
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_val);
        $display("MISMATCH at %0t: %s got %0h, want %0h", $time, what, got, exp_val);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_slot = 0;
            held       = 0;
            expected_q.delete();
        end else begin
            // Compare the output beat with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report("result beat with none pending", 64'(i_entry_count), 64'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_front_word !== want.front_word)
                        report("front_word", 64'(i_front_word), 64'(want.front_word));
                    if (i_back_word !== want.back_word)
                        report("back_word", 64'(i_back_word), 64'(want.back_word));
                    if (i_entry_count !== want.entry_count)
                        report("entry_count", 64'(i_entry_count), 64'(want.entry_count));
                    if (i_is_empty !== want.is_empty)
                        report("is_empty", 64'(i_is_empty), 64'(want.is_empty));
                    if (i_removed_count !== want.removed_count)
                        report("removed_count", 64'(i_removed_count), 64'(want.removed_count));
                    if (i_status !== want.status)
                        report("status", 64'(i_status), 64'(want.status));
                end
            end
            // Predict the result of an accepted input beat
            if (i_in_valid && i_in_ready) begin
                predict_beat(i_mode, i_value, want);
                expected_q.push_back(want);
            end
        end
        outstanding <= expected_q.size();
    end

endmodule

// File: bench/bounded_deque_with_remove_test.sv
// Testbench top: drives operation beats into the deque, paces the result side, gives the verdict.
`timescale 1ns / 1ps

module bounded_deque_with_remove_test;
    import dqr_pkg::*;

    // Mode code the block leaves unused
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

    localparam int RANDOM_BEATS = 2000;
    localparam int QUIET_FROM   = 1800;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = DEPTH_DEF + 16;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [MODE_W-1:0]        in_mode = '0;
    logic signed [WORD_W-1:0] in_value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] back_word;
    logic [CNT_O_W-1:0]       entry_count;
    logic                     is_empty;
    logic [CNT_O_W-1:0]       removed_count;
    logic [STAT_W-1:0]        status;

    int fail_count;
    int pending;
    int sent_count = 0;
    bit idle_on = 1'b1;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;
    int unsigned stall_cycles = 0;

    always #10 clk = ~clk;

    bounded_deque_with_remove dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_mode          (in_mode),
        .i_value         (in_value),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_front_word    (front_word),
        .o_back_word     (back_word),
        .o_entry_count   (entry_count),
        .o_is_empty      (is_empty),
        .o_removed_count (removed_count),
        .o_status        (status)
    );

    deque_result_checker #(.DEPTH(DEPTH_DEF)) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_mode          (in_mode),
        .i_value         (in_value),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_front_word    (front_word),
        .i_back_word     (back_word),
        .i_entry_count   (entry_count),
        .i_is_empty      (is_empty),
        .i_removed_count (removed_count),
        .i_status        (status),
        .o_fail_count    (fail_count),
        .o_pending_count (pending)
    );

    // Offer one beat, hold it until accepted, then maybe leave a gap
    task automatic offer(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] word);
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_value <= word;
        do @(posedge clk); while (!in_ready);
        sent_count++;
        idle_on = (sent_count < QUIET_FROM) && ((sent_count / 150) % 3 != 2);
        if (sent_count == HOLD_AT) hold_request = 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Bias the operation mix: fill the store, drain it, or keep it balanced
    function automatic logic [MODE_W-1:0] pick_mode(input int phase);
        int r;
        int push_w;
        int pop_w;
        r = $urandom_range(0, 99);
        case (phase)
            0:       begin push_w = 35; pop_w = 5;  end
            1:       begin push_w = 10; pop_w = 30; end
            default: begin push_w = 22; pop_w = 18; end
        endcase
        if (r < push_w) return MODE_PUSH_FRONT;
        r -= push_w;
        if (r < push_w) return MODE_PUSH_BACK;
        r -= push_w;
        if (r < pop_w) return MODE_POP_FRONT;
        r -= pop_w;
        if (r < pop_w) return MODE_POP_BACK;
        r -= pop_w;
        if (r < 6) return MODE_REMOVE;
        r -= 6;
        if (r < 6) return MODE_SHIFT_L;
        r -= 6;
        if (r < 6) return MODE_SHIFT_R;
        return MODE_UNUSED;
    endfunction

    // Draw mostly from a small set so removes hit several entries
    function automatic logic [WORD_W-1:0] pick_value();
        if ($urandom_range(0, 9) >= 6) return $urandom;
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h0000_0001;
            default: return 32'h0000_0005;
        endcase
    endfunction

    // Pace the result side; take one long hold-off so the block backs up
    initial begin
        forever begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty store: pops and remove are flagged or ignored
        offer(MODE_POP_FRONT, 32'h0000_0000);
        offer(MODE_POP_BACK, 32'h0000_0000);
        offer(MODE_REMOVE, 32'h0000_0000);
        // A shift on an empty store still pushes; a shift right and an unused mode follow on one entry
        offer(MODE_SHIFT_L, 32'h7FFF_FFFF);
        offer(MODE_SHIFT_R, 32'h8000_0000);
        offer(MODE_UNUSED, 32'hFFFF_FFFF);
        // Build a mix of extremes at both ends
        offer(MODE_PUSH_BACK, 32'hFFFF_FFFF);
        offer(MODE_PUSH_FRONT, 32'h0000_0000);
        offer(MODE_PUSH_BACK, 32'h8000_0000);
        offer(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
        offer(MODE_PUSH_BACK, 32'h0000_0000);
        // Remove matches inside and at the back end
        offer(MODE_REMOVE, 32'h0000_0000);
        offer(MODE_PUSH_FRONT, 32'h8000_0000);
        // Remove matches at the front, middle and back
        offer(MODE_REMOVE, 32'h8000_0000);
        offer(MODE_SHIFT_L, 32'h0000_0005);
        offer(MODE_SHIFT_R, 32'h0000_0006);
        offer(MODE_REMOVE, 32'h0000_3039);
        // Pop down to empty
        offer(MODE_POP_BACK, 32'h0000_0000);
        offer(MODE_POP_FRONT, 32'h0000_0000);
        offer(MODE_REMOVE, 32'hFFFF_FFFF);
        // Empty the store through a remove
        offer(MODE_PUSH_BACK, 32'h0000_0001);
        offer(MODE_REMOVE, 32'h0000_0001);

        // Random beats in fill, drain and balanced phases
        for (int i = 0; i < RANDOM_BEATS; i++)
            offer(pick_mode((i / 120) % 3), pick_value());
        in_valid <= 1'b0;

        // Let the last prediction land, drain outstanding results, then wait a sweep's worth
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
design/dqr_pkg.sv
design/dqr_ctrl.sv
design/dqr_dp.sv
design/bounded_deque_with_remove.sv
bench/deque_result_checker.sv
bench/bounded_deque_with_remove_test.sv
